// ----- src/id_allocator_with_status_unit_defines.svh -----
// Assertion helpers for the ID allocator.
`ifndef ID_ALLOCATOR_WITH_STATUS_UNIT_DEFINES_SVH
`define ID_ALLOCATOR_WITH_STATUS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/idalloc_pkg.sv -----
`default_nettype none

package idalloc_pkg;

  // Built capacity of the pool
  localparam int unsigned MAX_SLOTS = 128;
  localparam int unsigned SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned SIZE_W    = $clog2(MAX_SLOTS + 1);

  // Field widths
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned ERR_W    = 3;
  localparam int unsigned FIRST_W  = 15;
  localparam int unsigned POOL_W   = 8;
  localparam int unsigned CMP_W    = (SIZE_W > POOL_W) ? SIZE_W : POOL_W;

  // APB port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic REG_FIRST_ID  = 1'b0;
  localparam logic REG_POOL_SIZE = 1'b1;

  localparam logic [FIRST_W-1:0]  FIRST_ID_RESET = FIRST_W'(1);
  localparam logic [POOL_W-1:0]   POOL_RESET     = POOL_W'(100);
  localparam logic [STATUS_W-1:0] STATUS_ALLOC   = STATUS_W'(1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_READ    = 3'd2,
    OP_CHANGE  = 3'd3,
    OP_CHECK   = 3'd4
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK     = 3'd0,
    ERR_FULL   = 3'd1,
    ERR_RANGE  = 3'd2,
    ERR_FREE   = 3'd3,
    ERR_STATUS = 3'd4
  } err_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

`default_nettype wire

// ----- src/idalloc_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module idalloc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/id_allocator_with_status_unit.sv -----
// A request and its status RAM read are registered at accept; EXEC then writes
// the result register once it can take the result. A new request is taken only
//   in IDLE, after the status RAM read, the lookup, first-fit search and write-back.
// Reset: first_id = 1, pool_size = 100, every slot free (assigned map in
//   flops, cleared at once); the status RAM is not cleared and needs no sweep.
`default_nettype none

`include "id_allocator_with_status_unit_defines.svh"

module id_allocator_with_status_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [idalloc_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [idalloc_pkg::ID_W-1:0]        target_id_i,
  input  logic [idalloc_pkg::STATUS_W-1:0]    new_status_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [idalloc_pkg::ID_W-1:0]        given_id_o,
  output logic [idalloc_pkg::STATUS_W-1:0]    status_value_o,
  output logic [idalloc_pkg::ERR_W-1:0]       error_code_o,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [idalloc_pkg::APB_AW-1:0]      paddr,
  input  logic [idalloc_pkg::APB_DW-1:0]      pwdata,
  output logic [idalloc_pkg::APB_DW-1:0]      prdata,
  output logic                                pready
);

  import idalloc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FIRST_W-1:0] first_id_q;
  logic [POOL_W-1:0]  pool_size_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_id_q  <= FIRST_ID_RESET;
      pool_size_q <= POOL_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_FIRST_ID:  first_id_q  <= pwdata[FIRST_W-1:0];
        REG_POOL_SIZE: pool_size_q <= pwdata[POOL_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIRST_ID:  prdata = APB_DW'(first_id_q);
      REG_POOL_SIZE: prdata = APB_DW'(pool_size_q);
      default:       prdata = '0;
    endcase
  end

  // Live pool size: pool_size saturated to the built capacity.
  logic [CMP_W-1:0] live_size;
  assign live_size = (CMP_W'(pool_size_q) > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS)
                                                               : CMP_W'(pool_size_q);

  // ---------------------------------------------------------------------------
  // Control: IDLE accepts a transaction and launches the status read,
  // EXEC finishes it once the output register can take the result.
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_fire;
  logic   exec_go;

  assign in_fire = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_EXEC;
      ST_EXEC: if (exec_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b0;
    exec_go    = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EXEC: begin
        in_stall_o = 1'b1;
        // result register empty, or its content leaves this edge
        exec_go    = !out_valid_o || !out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: range check and slot number, captured with the request
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]     id_diff;
  logic                id_in_range;
  logic [OPCODE_W-1:0] op_q;
  logic [STATUS_W-1:0] new_status_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                in_range_q;

  assign id_diff     = target_id_i - ID_W'(first_id_q);
  assign id_in_range = (target_id_i >= ID_W'(first_id_q)) &&
                       (id_diff < ID_W'(live_size));

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q         <= opcode_i;
      new_status_q <= new_status_i;
      slot_q       <= id_diff[SLOT_W-1:0];
      in_range_q   <= id_in_range;
    end
  end

  // ---------------------------------------------------------------------------
  // Assigned map in flops (reset clears it) and first-fit search
  // ---------------------------------------------------------------------------
  logic [MAX_SLOTS-1:0] assigned_q;
  logic [MAX_SLOTS-1:0] free_vec;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;

  always_comb begin
    for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
      free_vec[i] = !assigned_q[i] && (CMP_W'(i) < live_size);
    end
  end

  // Lowest free slot wins: scan from the top so lower indexes overwrite.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Status RAM: read at accept, written back at the end of EXEC. The next
  // read comes only after the write, at a later accept in IDLE, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [STATUS_W-1:0] ram_wdata;
  logic [STATUS_W-1:0] ram_rdata;

  idalloc_ram #(
    .WIDTH (STATUS_W),
    .DEPTH (MAX_SLOTS)
  ) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (id_diff[SLOT_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Execute: decode the opcode, form the result and the state updates
  // ---------------------------------------------------------------------------
  logic                slot_assigned;
  logic [ID_W-1:0]     res_given;
  logic [STATUS_W-1:0] res_status;
  err_e                res_err;
  logic                map_set;
  logic                map_clr;
  logic                st_write;
  logic                alloc_ok;

  assign slot_assigned = assigned_q[slot_q];

  always_comb begin
    res_given  = '0;
    res_status = '0;
    res_err    = ERR_OK;
    map_set    = 1'b0;
    map_clr    = 1'b0;
    st_write   = 1'b0;
    unique case (op_q)
      OP_ALLOC: begin
        if (free_found) begin
          map_set   = 1'b1;
          res_given = ID_W'(first_id_q) + ID_W'(free_idx);
        end else begin
          res_err   = ERR_FULL;
        end
      end
      OP_RELEASE: begin
        if (!in_range_q)         res_err = ERR_RANGE;
        else if (!slot_assigned) res_err = ERR_FREE;
        else                     map_clr = 1'b1;
      end
      OP_READ: begin
        if (!in_range_q)        res_err    = ERR_RANGE;
        else if (slot_assigned) res_status = ram_rdata;
      end
      OP_CHANGE: begin
        // zero status is rejected ahead of the range check
        if (new_status_q == '0)  res_err  = ERR_STATUS;
        else if (!in_range_q)    res_err  = ERR_RANGE;
        else if (!slot_assigned) res_err  = ERR_FREE;
        else                     st_write = 1'b1;
      end
      OP_CHECK: begin
        if (!in_range_q) res_err = ERR_RANGE;
      end
      default: ;  // unused opcodes answer all zero
    endcase
  end

  assign alloc_ok  = exec_go && map_set;
  assign ram_we    = exec_go && (map_set || st_write);
  assign ram_waddr = map_set ? free_idx : slot_q;
  assign ram_wdata = map_set ? STATUS_ALLOC : new_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assigned_q <= '0;
    end else if (exec_go) begin
      if (map_set) assigned_q[free_idx] <= 1'b1;
      if (map_clr) assigned_q[slot_q]   <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: holds a finished transaction while the sink stalls,
  // so the next request can already be taken in IDLE.
  // ---------------------------------------------------------------------------
  logic                out_valid_q;
  logic [ID_W-1:0]     given_id_q;
  logic [STATUS_W-1:0] status_value_q;
  logic [ERR_W-1:0]    error_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      given_id_q     <= res_given;
      status_value_q <= res_status;
      error_code_q   <= res_err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign given_id_o     = given_id_q;
  assign status_value_o = status_value_q;
  assign error_code_o   = error_code_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IDA_ASSERT_NOW(a_result_from_exec, $rose(out_valid_o), $past(state_q == ST_EXEC),
                  "result appeared without an executed request")
  `IDA_ASSERT_NEXT(a_alloc_marks_slot, alloc_ok, assigned_q[$past(free_idx)],
                   "allocated slot not marked assigned")
  `IDA_ASSERT_NOW(a_given_only_on_ok, out_valid_o && (given_id_o != '0),
                  error_code_o == ERR_OK, "given_id set on a failed request")
  `IDA_ASSERT_NOW(a_status_only_on_ok, out_valid_o && (status_value_o != '0),
                  error_code_o == ERR_OK, "status_value set on a failed request")

endmodule

`default_nettype wire
